### rtl/core/mbsp_pkg.sv
// -----------------------------------------------------------------------------
// MIDI byte stream parser package
// Shared codes, result types and tick arithmetic helpers.
// -----------------------------------------------------------------------------
package mbsp_pkg;

  localparam logic [6:0] SYS_SYSEX_BEGIN  = 7'h70;
  localparam logic [6:0] SYS_SYSEX_END    = 7'h77;
  localparam logic [6:0] SYS_CLOCK        = 7'h78;
  localparam logic [6:0] SYS_START        = 7'h7a;
  localparam logic [6:0] SYS_STOP         = 7'h7c;
  localparam logic [6:0] SYS_ACTIVE_SENSE = 7'h7e;

  localparam logic [15:0] CLOCK_STEP        = 16'd26666;
  localparam logic [15:0] SOFT_STEP_RESET   = 16'd12800;
  localparam int          TICK_UNIT         = 10000;
  localparam logic [9:0]  SYSEX_MAX_LENGTH  = 10'd1023;

  localparam int TDATA_OUT_W = 48;

  typedef enum logic [2:0] {
    KIND_CHANNEL    = 3'd0,
    KIND_SYSEX_BYTE = 3'd1,
    KIND_SYSEX_END  = 3'd2,
    KIND_START      = 3'd3,
    KIND_STOP       = 3'd4,
    KIND_TICK       = 3'd5
  } kind_t;

  typedef enum logic {
    REG_RUN_ENABLE     = 1'b0,
    REG_SOFT_TICK_STEP = 1'b1
  } reg_index_t;

  typedef struct packed {
    logic        valid;
    kind_t       kind;
    logic [6:0]  status_bits;
    logic [6:0]  first_data;
    logic [6:0]  second_data;
    logic [6:0]  sysex_data;
    logic [9:0]  sysex_length;
    logic [2:0]  tick_count;
  } result_t;

  typedef struct packed {
    logic        run_enable;
    logic [15:0] soft_tick_step;
    logic        acc_clear;
  } cfg_t;

  function automatic logic [2:0] tick_whole(input logic [16:0] sum);
    logic [2:0] w;
    w = '0;
    for (int k = 1; k <= 7; k++) begin
      if (sum >= 17'(k * TICK_UNIT)) begin
        w = 3'(k);
      end
    end
    return w;
  endfunction

  function automatic logic [13:0] tick_remainder(input logic [16:0] sum,
                                                 input logic [2:0] w);
    logic [16:0] taken;
    taken = 17'(int'(w) * TICK_UNIT);
    return 14'(sum - taken);
  endfunction

endpackage

### rtl/core/mbsp_regs.sv
// -----------------------------------------------------------------------------
// MIDI parser configuration registers
// APB-style register file holding run enable and the soft tick step.
// -----------------------------------------------------------------------------
module mbsp_regs (
  input  logic                clk,
  input  logic                rst,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready,
  output mbsp_pkg::cfg_t      cfg
);

  logic        run_enable;
  logic [15:0] soft_tick_step;
  logic        acc_clear;
  logic        wr;
  mbsp_pkg::reg_index_t idx;

  assign pready = 1'b1;
  assign wr     = psel & penable & pwrite & pready;
  assign idx    = mbsp_pkg::reg_index_t'(paddr[2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      run_enable     <= 1'b0;
      soft_tick_step <= mbsp_pkg::SOFT_STEP_RESET;
      acc_clear      <= 1'b0;
    end else begin
      acc_clear <= 1'b0;
      if (wr) begin
        unique case (idx)
          mbsp_pkg::REG_RUN_ENABLE: begin
            run_enable <= pwdata[0];
            acc_clear  <= 1'b1;
          end
          mbsp_pkg::REG_SOFT_TICK_STEP: begin
            soft_tick_step <= pwdata[15:0];
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_comb begin
    unique case (idx)
      mbsp_pkg::REG_RUN_ENABLE:     prdata = {31'd0, run_enable};
      mbsp_pkg::REG_SOFT_TICK_STEP: prdata = {16'd0, soft_tick_step};
      default:                      prdata = '0;
    endcase
  end

  assign cfg.run_enable     = run_enable;
  assign cfg.soft_tick_step = soft_tick_step;
  assign cfg.acc_clear      = acc_clear;

endmodule

### rtl/core/mbsp_tick.sv
// -----------------------------------------------------------------------------
// MIDI parser tick accumulator
// Adds clock or soft tick steps and takes out whole ticks of 10000 units.
// -----------------------------------------------------------------------------
module mbsp_tick (
  input  logic                 clk,
  input  logic                 rst,
  input  mbsp_pkg::cfg_t       cfg,
  input  logic                 update,
  input  logic                 soft_tick,
  output mbsp_pkg::result_t    result
);

  logic [13:0] acc;
  logic [13:0] acc_next;
  logic [15:0] amount;
  logic [16:0] sum;
  logic [2:0]  whole;

  assign amount   = soft_tick ? cfg.soft_tick_step : mbsp_pkg::CLOCK_STEP;
  assign sum      = {3'd0, acc} + {1'b0, amount};
  assign whole    = mbsp_pkg::tick_whole(sum);
  assign acc_next = mbsp_pkg::tick_remainder(sum, whole);

  always_ff @(posedge clk) begin
    if (rst || cfg.acc_clear) begin
      acc <= '0;
    end else if (update) begin
      acc <= acc_next;
    end
  end

  always_comb begin
    result            = '0;
    result.kind       = mbsp_pkg::KIND_TICK;
    result.tick_count = whole;
    result.valid      = (whole != 3'd0) && cfg.run_enable;
  end

endmodule

### rtl/core/mbsp_parser.sv
// -----------------------------------------------------------------------------
// MIDI parser message state
// Tracks channel messages, sysex framing and start/stop for non-tick bytes.
// -----------------------------------------------------------------------------
module mbsp_parser (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 update,
  input  logic [7:0]           midi_byte,
  output mbsp_pkg::result_t    result
);

  typedef enum logic [1:0] {
    POS_FIRST  = 2'd0,
    POS_SECOND = 2'd1,
    POS_IDLE   = 2'd3
  } pos_t;

  pos_t        pos;
  pos_t        pos_next;
  logic [6:0]  status_hold;
  logic [6:0]  status_hold_next;
  logic [6:0]  first_hold;
  logic [6:0]  first_hold_next;
  logic        sysex_active;
  logic        sysex_active_next;
  logic [9:0]  sysex_counter;
  logic [9:0]  sysex_counter_next;
  logic [6:0]  low;
  logic        pending;

  assign low     = midi_byte[6:0];
  assign pending = (pos == POS_FIRST) || (pos == POS_SECOND);

  always_comb begin
    pos_next           = pos;
    status_hold_next   = status_hold;
    first_hold_next    = first_hold;
    sysex_active_next  = sysex_active;
    sysex_counter_next = sysex_counter;
    result             = '0;
    result.kind        = mbsp_pkg::KIND_CHANNEL;
    if (midi_byte[7]) begin
      unique case (low)
        mbsp_pkg::SYS_CLOCK, mbsp_pkg::SYS_ACTIVE_SENSE: begin
        end
        mbsp_pkg::SYS_START: begin
          result.valid = 1'b1;
          result.kind  = mbsp_pkg::KIND_START;
        end
        mbsp_pkg::SYS_STOP: begin
          result.valid = 1'b1;
          result.kind  = mbsp_pkg::KIND_STOP;
        end
        mbsp_pkg::SYS_SYSEX_BEGIN: begin
          sysex_active_next  = 1'b1;
          sysex_counter_next = '0;
        end
        mbsp_pkg::SYS_SYSEX_END: begin
          result.valid        = 1'b1;
          result.kind         = mbsp_pkg::KIND_SYSEX_END;
          result.sysex_length = sysex_counter;
          sysex_active_next   = 1'b0;
          sysex_counter_next  = '0;
        end
        default: begin
          result.valid       = pending;
          result.status_bits = pending ? status_hold : 7'd0;
          result.first_data  = pending ? first_hold : 7'd0;
          status_hold_next   = low;
          first_hold_next    = '0;
          pos_next           = POS_FIRST;
        end
      endcase
    end else if (sysex_active) begin
      if (sysex_counter < mbsp_pkg::SYSEX_MAX_LENGTH) begin
        sysex_counter_next = sysex_counter + 10'd1;
      end
      result.valid      = 1'b1;
      result.kind       = mbsp_pkg::KIND_SYSEX_BYTE;
      result.sysex_data = low;
    end else begin
      unique case (pos)
        POS_FIRST: begin
          first_hold_next = low;
          pos_next        = POS_SECOND;
        end
        POS_SECOND: begin
          pos_next           = POS_IDLE;
          result.valid       = 1'b1;
          result.status_bits = status_hold;
          result.first_data  = first_hold;
          result.second_data = low;
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos           <= POS_IDLE;
      status_hold   <= '0;
      first_hold    <= '0;
      sysex_active  <= 1'b0;
      sysex_counter <= '0;
    end else if (update) begin
      pos           <= pos_next;
      status_hold   <= status_hold_next;
      first_hold    <= first_hold_next;
      sysex_active  <= sysex_active_next;
      sysex_counter <= sysex_counter_next;
    end
  end

endmodule

### rtl/core/midi_byte_stream_parser_core.sv
// -----------------------------------------------------------------------------
// MIDI byte stream parser core
// Parses MIDI bytes and soft tick events into channel, sysex, transport and
// tick results.
// -----------------------------------------------------------------------------
// The core accepts one request per clock cycle while the output is not
// stalled: a request is captured in an input register, decoded in a single
// pass that updates the message and tick state, and the result, if any, is
// placed in the output register. Bytes that produce no result (data bytes
// held for later, active sensing, sysex begin, ticks below a whole unit or
// ticks while run is off) are consumed without output. When the output
// register is stalled, one further request is held in the input register
// before s_tready drops.
module midi_byte_stream_parser_core (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [7:0]                      s_tdata,   // [7:0] midi_byte
  input  logic [0:0]                      s_tuser,   // [0] operation
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // [6:0] status_bits, [13:7] first_data, [20:14] second_data,
  // [27:21] sysex_data, [37:28] sysex_length, [40:38] tick_count
  output logic [mbsp_pkg::TDATA_OUT_W-1:0] m_tdata,
  output logic [2:0]                      m_tuser,   // [2:0] kind
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready
);

  mbsp_pkg::cfg_t    cfg;
  mbsp_pkg::result_t tick_result;
  mbsp_pkg::result_t parse_result;
  mbsp_pkg::result_t result;
  mbsp_pkg::result_t out_reg;

  logic       in_vld;
  logic       in_op;
  logic [7:0] in_byte;
  logic       fire;
  logic       is_tick;

  assign fire     = in_vld && (!m_tvalid || m_tready);
  assign s_tready = !in_vld || fire;
  assign is_tick  = in_op || (in_byte[7] && (in_byte[6:0] == mbsp_pkg::SYS_CLOCK));

  always_ff @(posedge clk) begin
    if (rst) begin
      in_vld <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      in_vld <= 1'b1;
    end else if (fire) begin
      in_vld <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_op   <= s_tuser[0];
      in_byte <= s_tdata;
    end
  end

  mbsp_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  mbsp_tick u_tick (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .update    (fire && is_tick),
    .soft_tick (in_op),
    .result    (tick_result)
  );

  mbsp_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .update    (fire && !is_tick),
    .midi_byte (in_byte),
    .result    (parse_result)
  );

  assign result = is_tick ? tick_result : parse_result;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fire) begin
      m_tvalid <= result.valid;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_reg <= result;
    end
  end

  assign m_tuser = out_reg.kind;
  assign m_tdata = {7'd0, out_reg.tick_count, out_reg.sysex_length, out_reg.sysex_data,
                    out_reg.second_data, out_reg.first_data, out_reg.status_bits};

`ifndef SYNTHESIS
  a_tick_nonzero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_reg.kind == mbsp_pkg::KIND_TICK) |-> (out_reg.tick_count != 3'd0))
    else $error("tick result with zero count");

  a_tready_hold: assert property (@(posedge clk) disable iff (rst)
    !s_tready |-> in_vld && m_tvalid && !m_tready)
    else $error("input stalled without a held request");

  a_status_clean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (out_reg.kind != mbsp_pkg::KIND_CHANNEL) |->
      (out_reg.status_bits == 7'd0) && (out_reg.first_data == 7'd0))
    else $error("channel fields set on a non-channel result");

  a_reset_empty: assert property (@(posedge clk)
    !rst && $past(rst) |-> !m_tvalid && !in_vld)
    else $error("pipeline not empty after reset");
`endif

endmodule
